// ----- src/lcdns_pkg.sv -----
package lcdns_pkg;

  // Request codes
  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_INIT   = 3'd1;
  localparam logic [2:0] MODE_CLEAR  = 3'd2;
  localparam logic [2:0] MODE_LINE   = 3'd3;
  localparam logic [2:0] MODE_SCROLL = 3'd4;

  // Command bytes
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_LINE_1    = 8'h80;
  localparam logic [7:0] CMD_LINE_2    = 8'hC0;
  localparam logic [7:0] CMD_SCROLL    = 8'h18;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

  // Hold times in microseconds
  localparam logic [15:0] HOLD_EN_HIGH   = 16'd2;
  localparam logic [15:0] HOLD_EN_LOW    = 16'd5;
  localparam logic [15:0] HOLD_BYTE_DONE = 16'd55;
  localparam logic [15:0] HOLD_CMD_DONE  = 16'd94;
  localparam logic [15:0] HOLD_CLR_DONE  = 16'd2055;
  localparam logic [15:0] HOLD_RAW_LOW   = 16'd44;
  localparam logic [15:0] HOLD_POWER_ON  = 16'd50000;

  // Last step index of each run
  localparam logic [4:0] LAST_STEP_BYTE = 5'd3;
  localparam logic [4:0] LAST_STEP_INIT = 5'd28;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_CMD,
    WAIT_CLEAR
  } wait_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] byte_value;
    logic       rs_data;
    logic [1:0] line;
  } req_t;

  typedef struct packed {
    logic        rs_level;
    logic [3:0]  data_nibble;
    logic        enable_level;
    logic [15:0] hold_us;
    logic        last;
  } res_t;

  // Classified request, passed from front end to back end
  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] byte_v;
    wait_e      wait_sel;
  } cmd_t;

endpackage

// ----- src/lcdns_front.sv -----
module lcdns_front (
  input  lcdns_pkg::req_t req_i,
  output logic            cmd_valid_o,
  output lcdns_pkg::cmd_t cmd_o
);

  always_comb begin
    cmd_valid_o     = 1'b1;
    cmd_o.init      = 1'b0;
    cmd_o.rs        = 1'b0;
    cmd_o.byte_v    = req_i.byte_value;
    cmd_o.wait_sel  = lcdns_pkg::WAIT_NONE;
    unique case (req_i.mode)
      lcdns_pkg::MODE_WRITE: begin
        cmd_o.rs = req_i.rs_data;
      end
      lcdns_pkg::MODE_INIT: begin
        cmd_o.init = 1'b1;
      end
      lcdns_pkg::MODE_CLEAR: begin
        cmd_o.byte_v   = lcdns_pkg::CMD_CLEAR;
        cmd_o.wait_sel = lcdns_pkg::WAIT_CLEAR;
      end
      lcdns_pkg::MODE_LINE: begin
        // drop requests for lines other than one and two
        cmd_o.byte_v = (req_i.line == 2'd2) ? lcdns_pkg::CMD_LINE_2 : lcdns_pkg::CMD_LINE_1;
        cmd_valid_o  = (req_i.line == 2'd1) || (req_i.line == 2'd2);
      end
      lcdns_pkg::MODE_SCROLL: begin
        cmd_o.byte_v = lcdns_pkg::CMD_SCROLL;
      end
      default: begin
        cmd_valid_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/lcdns_cmd_fifo.sv -----
module lcdns_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcdns_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lcdns_pkg::cmd_t cmd_o
);

  lcdns_pkg::cmd_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- src/lcdns_back.sv -----
module lcdns_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  lcdns_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output lcdns_pkg::res_t res_o
);

  logic [4:0]      step_q, step_d;
  logic            out_valid_q, out_valid_d;
  lcdns_pkg::res_t out_q;
  lcdns_pkg::res_t ev;
  logic            slot_free, emit, run_done;

  // Byte run: high nibble then low nibble, enable high then low
  function automatic lcdns_pkg::res_t byte_event(logic rs, logic [7:0] b, logic [1:0] s,
                                                 logic [15:0] done_hold);
    lcdns_pkg::res_t r;
    r.rs_level     = rs;
    r.data_nibble  = s[1] ? b[3:0] : b[7:4];
    r.enable_level = !s[0];
    r.hold_us      = s[0] ? (s[1] ? done_hold : lcdns_pkg::HOLD_EN_LOW) : lcdns_pkg::HOLD_EN_HIGH;
    r.last         = (s == 2'd3);
    return r;
  endfunction

  function automatic logic [7:0] init_byte(logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = lcdns_pkg::CMD_FUNC_SET;
      3'd1:    b = lcdns_pkg::CMD_DISP_OFF;
      3'd2:    b = lcdns_pkg::CMD_CLEAR;
      3'd3:    b = lcdns_pkg::CMD_ENTRY;
      default: b = lcdns_pkg::CMD_DISP_ON;
    endcase
    return b;
  endfunction

  function automatic lcdns_pkg::res_t init_event(logic [4:0] i);
    lcdns_pkg::res_t r;
    logic [2:0]      j;
    logic [4:0]      k;
    j = 3'(i - 5'd1);
    k = i - 5'd9;
    r = '0;
    if (i == 5'd0) begin
      r.hold_us = lcdns_pkg::HOLD_POWER_ON;
    end else if (i <= 5'd8) begin
      // raw wake-up nibbles, three then the switch to four-bit mode
      r.data_nibble  = (j[2:1] == 2'd3) ? lcdns_pkg::NIB_FOUR_BIT : lcdns_pkg::NIB_WAKE;
      r.enable_level = !j[0];
      r.hold_us      = j[0] ? lcdns_pkg::HOLD_RAW_LOW : lcdns_pkg::HOLD_EN_HIGH;
    end else begin
      r = byte_event(1'b0, init_byte(k[4:2]), k[1:0],
                     (k[4:2] == 3'd2) ? lcdns_pkg::HOLD_CLR_DONE : lcdns_pkg::HOLD_CMD_DONE);
      r.last = (i == lcdns_pkg::LAST_STEP_INIT);
    end
    return r;
  endfunction

  function automatic logic [15:0] done_hold(lcdns_pkg::wait_e w);
    logic [15:0] h;
    unique case (w)
      lcdns_pkg::WAIT_CMD:   h = lcdns_pkg::HOLD_CMD_DONE;
      lcdns_pkg::WAIT_CLEAR: h = lcdns_pkg::HOLD_CLR_DONE;
      default:               h = lcdns_pkg::HOLD_BYTE_DONE;
    endcase
    return h;
  endfunction

  always_comb begin
    if (cmd_i.init) begin
      ev = init_event(step_q);
    end else begin
      ev = byte_event(cmd_i.rs, cmd_i.byte_v, step_q[1:0], done_hold(cmd_i.wait_sel));
    end
  end

  assign slot_free = !out_valid_q || pop_i;
  assign emit      = cmd_valid_i && slot_free;
  assign run_done  = cmd_i.init ? (step_q == lcdns_pkg::LAST_STEP_INIT)
                                : (step_q == lcdns_pkg::LAST_STEP_BYTE);
  assign cmd_pop_o = emit && run_done;
  assign empty_o   = !out_valid_q;
  assign res_o     = out_q;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      step_d      = run_done ? 5'd0 : step_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= ev;
    end
  end

endmodule

// ----- src/char_lcd_nibble_sequencer_top.sv -----
// Pin-event sequencer for a 4-bit character LCD.
// Request side: drive req_i and raise push; a request is taken at a rising
// edge with push high and full low. Result side: while empty is low,
// res_o shows the oldest pin event; raise pop to take it.
// Each event gives the RS, DB7..DB4 and E levels and a hold time in us;
// last marks the final event of a request's run.
// The first event of a request passes the request queue, then the output register.
// Throughput: the back-end sequencer gives one event per cycle while the
// receiver keeps up; a byte request (write, clear, set line, scroll) has 4 events, init 29.
// Set line with a line other than one or two, and unused modes, give no
// events; they are taken and dropped without entering the queue.
// A two-entry request queue sits between the classifying front end and the
// sequencer. The running request keeps its entry until its last event has
// gone out, so one more request can wait behind it.
// When the receiver stalls, the current event holds in the output register,
// the sequencer halts, and full rises once the queue is full.
// Reset empties the queue and the output register.
module char_lcd_nibble_sequencer_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  lcdns_pkg::req_t req_i,
  output logic            empty,
  input  logic            pop,
  output lcdns_pkg::res_t res_o
);

  logic            front_valid;
  lcdns_pkg::cmd_t front_cmd;
  logic            q_valid;
  lcdns_pkg::cmd_t q_cmd;
  logic            q_pop;

  // Classify the request and drop those that give no events
  lcdns_front u_front (
    .req_i       (req_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  // Hold classified requests until the sequencer is ready
  lcdns_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && front_valid),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Advance through the pin events of the head request
  lcdns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_o)
  );

endmodule
